@@ src/tscf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscf_pkg: shared constants and types for the tempo step clock follower
// Request codes, register indexes, reset values and the divider control bundle.
// ----------------------------------------------------------------------------
package tscf_pkg;

    localparam int unsigned DEF_TIME_WIDTH = 24;
    localparam int unsigned DEF_MAX_FACTOR = 16;

    localparam int unsigned STEP_W        = 8;
    localparam int unsigned FACTOR_REG_W  = 5;
    localparam int unsigned FACTOR_EXT_W  = 7;
    localparam int unsigned DEN_W         = 8;
    localparam int unsigned DIV_CNT_W     = 6;
    localparam int unsigned OP_W          = 2;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 8;

    localparam int unsigned RESET_PERIOD    = 60000 / 90;
    localparam int unsigned RESET_MAX_STEPS = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SYNC  = 2'd1;
    localparam logic [OP_W-1:0] OP_PULSE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEPS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_FACTOR = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] bits;
    } div_ctrl_t;

endpackage
`default_nettype wire

@@ src/tscf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscf_div: bit-serial restoring divider
// One quotient bit per cycle, most significant first, over a left-aligned
// dividend of ctrl.bits bits; the divisor must be non-zero and held stable.
// ----------------------------------------------------------------------------
module tscf_div
    import tscf_pkg::*;
#(
    parameter int unsigned N = DEF_TIME_WIDTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire div_ctrl_t       ctrl,
    input  wire logic [N-1:0]    dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                 done,
    output logic [N-1:0]         quotient,
    output logic [DEN_W-1:0]     remainder
);

    logic [N-1:0]         shift_reg, shift_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    always_comb
    begin
        trial      = {rem_reg, shift_reg[N-1]};
        diff       = trial - {1'b0, divisor};
        fits       = (trial >= {1'b0, divisor});
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = ctrl.bits;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit left
            shift_next = {shift_reg[N-2:0], fits};
            rem_next   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ src/tscf_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscf_mul: bit-serial shift-add multiplier with saturation
// Walks the narrow multiplier one bit per cycle, most significant first, and
// clamps the product to the all-ones time value.
// ----------------------------------------------------------------------------
module tscf_mul
    import tscf_pkg::*;
#(
    parameter int unsigned TW = DEF_TIME_WIDTH,
    parameter int unsigned FW = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [TW-1:0] mcand,
    input  wire logic [FW-1:0] mplier,
    output logic               done,
    output logic [TW-1:0]      product
);

    localparam int unsigned ACC_W = TW + FW;
    localparam int unsigned CNT_W = $clog2(FW + 1);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [FW-1:0]    bits_reg, bits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            bits_next = mplier;
            cnt_next  = CNT_W'(FW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[ACC_W-2:0], 1'b0}
                      + (bits_reg[FW-1] ? ACC_W'(mcand) : '0);
            bits_next = {bits_reg[FW-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        bits_reg <= bits_next;
    end

    assign done    = done_reg;
    assign product = (|acc_reg[ACC_W-1:TW]) ? {TW{1'b1}} : acc_reg[TW-1:0];

endmodule
`default_nettype wire

@@ src/tempo_step_clock_follower.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tempo_step_clock_follower: sequencer step clock locked to a master clock
// Counts millisecond ticks against the step period, takes the period from
// master syncs or external pulses, and advances the wrapping step counter.
// ----------------------------------------------------------------------------
//  channel   handshake                fields
//  item      item_valid / item_ready  op, master_period_ms, master_step
//  result    result_valid / result_ready
//                                     step_fired, step_index, period_out_ms,
//                                     elapsed_out_ms
//  config    cfg_we                   cfg_index, cfg_data
//
// One request at a time. A step advance runs a serial modulo of the counter
// (9 bits) on the shared divider. A divide-mode sync runs the divider over
// TIME_WIDTH bits and then the step advance; a multiply-mode sync runs the
// shift-add multiplier, then an 8-bit modulo of the master step, and the step
// advance only when that modulo leaves no remainder.
// A result waiting in the output register holds the block only once the next
// request has finished. Reset clears the step counter and elapsed time, and
// restores the period (666 ms) and the configuration registers to defaults.
// ----------------------------------------------------------------------------
module tempo_step_clock_follower
    import tscf_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH,
    parameter int unsigned MAX_FACTOR = DEF_MAX_FACTOR
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [OP_W-1:0]        op,
    input  wire logic [TIME_WIDTH-1:0]  master_period_ms,
    input  wire logic [STEP_W-1:0]      master_step,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic                        step_fired,
    output logic [STEP_W-1:0]           step_index,
    output logic [TIME_WIDTH-1:0]       period_out_ms,
    output logic [TIME_WIDTH-1:0]       elapsed_out_ms
);

    localparam int unsigned FW = $clog2(MAX_FACTOR + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_MUL       = 4'd2;
    localparam logic [3:0] S_SDIV      = 4'd3;
    localparam logic [3:0] S_PDIV      = 4'd4;
    localparam logic [3:0] S_ADV_START = 4'd5;
    localparam logic [3:0] S_ADV       = 4'd6;
    localparam logic [3:0] S_DONE      = 4'd7;

    logic [3:0]              state_reg, state_next;
    logic [STEP_W-1:0]       max_steps_reg;
    logic                    rate_mode_reg;
    logic [FACTOR_REG_W-1:0] rate_factor_reg;
    logic [STEP_W-1:0]       step_counter_reg, step_counter_next;
    logic [TIME_WIDTH-1:0]   period_reg, period_next;
    logic [TIME_WIDTH-1:0]   elapsed_reg, elapsed_next;
    logic                    fired_reg, fired_next;
    logic [OP_W-1:0]         op_reg;
    logic [TIME_WIDTH-1:0]   mper_reg;
    logic [STEP_W-1:0]       mstep_reg;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_fired_reg;
    logic [STEP_W-1:0]       res_step_reg;
    logic [TIME_WIDTH-1:0]   res_period_reg;
    logic [TIME_WIDTH-1:0]   res_elapsed_reg;

    logic [FACTOR_EXT_W-1:0] factor_ext;
    logic [FACTOR_EXT_W-1:0] eff_factor;
    logic [STEP_W-1:0]       eff_max;
    logic [STEP_W:0]         cnt_plus1;
    logic [TIME_WIDTH-1:0]   elapsed_inc;
    logic                    item_take;
    logic                    res_load;

    div_ctrl_t               div_ctrl;
    logic [TIME_WIDTH-1:0]   div_dividend;
    logic [DEN_W-1:0]        div_divisor;
    logic                    div_done;
    logic [TIME_WIDTH-1:0]   div_quotient;
    logic [DEN_W-1:0]        div_remainder;
    logic                    mul_start;
    logic                    mul_done;
    logic [TIME_WIDTH-1:0]   mul_product;

    // clamp the factor into 1..MAX_FACTOR
    always_comb
    begin
        factor_ext = FACTOR_EXT_W'(rate_factor_reg);
        if (factor_ext == '0)
            eff_factor = FACTOR_EXT_W'(1);
        else if (factor_ext > FACTOR_EXT_W'(MAX_FACTOR))
            eff_factor = FACTOR_EXT_W'(MAX_FACTOR);
        else
            eff_factor = factor_ext;
    end

    assign eff_max     = (max_steps_reg == '0) ? STEP_W'(1) : max_steps_reg;
    assign cnt_plus1   = {1'b0, step_counter_reg} + (STEP_W+1)'(1);
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign item_ready  = (state_reg == S_IDLE);
    assign item_take   = item_valid && item_ready;
    assign res_load    = (state_reg == S_DONE) && (!res_valid_reg || result_ready);

    // divider operand selection follows the sequencer state
    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_ctrl.bits  = DIV_CNT_W'(TIME_WIDTH);
        div_dividend   = mper_reg;
        div_divisor    = DEN_W'(eff_factor);
        mul_start      = 1'b0;
        case (state_reg)
            S_DISPATCH:
            begin
                if (op_reg == OP_SYNC)
                begin
                    mul_start      = rate_mode_reg;
                    div_ctrl.start = !rate_mode_reg;
                end
            end
            S_MUL:
            begin
                div_ctrl.start = mul_done;
                div_ctrl.bits  = DIV_CNT_W'(STEP_W);
                div_dividend   = {mstep_reg, {(TIME_WIDTH-STEP_W){1'b0}}};
            end
            S_ADV_START:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.bits  = DIV_CNT_W'(STEP_W + 1);
                div_dividend   = {cnt_plus1, {(TIME_WIDTH-STEP_W-1){1'b0}}};
                div_divisor    = eff_max;
            end
            S_ADV:
            begin
                div_divisor = eff_max;
            end
            default:
            begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        step_counter_next = step_counter_reg;
        period_next       = period_reg;
        elapsed_next      = elapsed_reg;
        fired_next        = fired_reg;
        res_valid_next    = res_valid_reg;
        if (result_valid && result_ready)
            res_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                fired_next = 1'b0;
                if (item_take)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        elapsed_next = elapsed_inc;
                        state_next   = (elapsed_inc > period_reg) ? S_ADV_START : S_DONE;
                    end
                    OP_SYNC:
                    begin
                        state_next = rate_mode_reg ? S_MUL : S_PDIV;
                    end
                    OP_PULSE:
                    begin
                        period_next = elapsed_reg;
                        state_next  = S_ADV_START;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    period_next = mul_product;
                    state_next  = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_done)
                    state_next = (div_remainder == '0) ? S_ADV_START : S_DONE;
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    period_next = div_quotient;
                    state_next  = S_ADV_START;
                end
            end
            S_ADV_START:
            begin
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (div_done)
                begin
                    step_counter_next = div_remainder;
                    elapsed_next      = '0;
                    fired_next        = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            max_steps_reg    <= STEP_W'(RESET_MAX_STEPS);
            rate_mode_reg    <= 1'b0;
            rate_factor_reg  <= FACTOR_REG_W'(1);
            step_counter_reg <= '0;
            period_reg       <= TIME_WIDTH'(RESET_PERIOD);
            elapsed_reg      <= '0;
            fired_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_counter_reg <= step_counter_next;
            period_reg       <= period_next;
            elapsed_reg      <= elapsed_next;
            fired_reg        <= fired_next;
            res_valid_reg    <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_STEPS:   max_steps_reg   <= cfg_data;
                    CFG_RATE_MODE:   rate_mode_reg   <= cfg_data[0];
                    CFG_RATE_FACTOR: rate_factor_reg <= cfg_data[FACTOR_REG_W-1:0];
                    default:         max_steps_reg   <= max_steps_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            op_reg    <= op;
            mper_reg  <= master_period_ms;
            mstep_reg <= master_step;
        end
        if (res_load)
        begin
            res_fired_reg   <= fired_reg;
            res_step_reg    <= step_counter_reg;
            res_period_reg  <= period_reg;
            res_elapsed_reg <= elapsed_reg;
        end
    end

    tscf_div #(
        .N (TIME_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    tscf_mul #(
        .TW (TIME_WIDTH),
        .FW (FW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mper_reg),
        .mplier  (eff_factor[FW-1:0]),
        .done    (mul_done),
        .product (mul_product)
    );

    assign result_valid   = res_valid_reg;
    assign step_fired     = res_fired_reg;
    assign step_index     = res_step_reg;
    assign period_out_ms  = res_period_reg;
    assign elapsed_out_ms = res_elapsed_reg;

endmodule
`default_nettype wire

@@ src/tscf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscf_checker: port-level checks for the tempo step clock follower
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tscf_checker
    import tscf_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_ready,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic                  step_fired,
    input wire logic [STEP_W-1:0]     step_index,
    input wire logic [TIME_WIDTH-1:0] elapsed_out_ms
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(step_index) && $stable(step_fired)
            && $stable(elapsed_out_ms))
        else $error("result changed while stalled");

    // one request in flight: ready drops after a take
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken while busy");

    // a step always restarts the elapsed time
    a_step_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && step_fired |-> elapsed_out_ms == '0)
        else $error("step fired with elapsed time left");

    // a fresh result only appears after the block was busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without work");

endmodule

bind tempo_step_clock_follower tscf_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_tscf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .step_fired     (step_fired),
    .step_index     (step_index),
    .elapsed_out_ms (elapsed_out_ms)
);
`default_nettype wire
